>>> src/krg_pkg.sv
// Package for the key repeat generator: command, action and register codes,
// the result record type and the timer limit. No dependencies.
`timescale 1ns / 1ps

package krg_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_TOGGLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result action codes.
    localparam logic [1:0] ACT_PASS    = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_LED     = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_DELAY    = 3'd0;
    localparam logic [2:0] REG_INTERVAL = 3'd1;
    localparam logic [2:0] REG_EXCLUDED = 3'd2;
    localparam logic [2:0] REG_FIRST    = 3'd3;
    localparam logic [2:0] REG_LAST     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] DELAY_RST    = 16'd115;
    localparam logic [6:0]  INTERVAL_RST = 7'd13;
    localparam logic [15:0] EXCLUDED_RST = 16'd44;
    localparam logic [15:0] FIRST_RST    = 16'd4;
    localparam logic [15:0] LAST_RST     = 16'd82;

    // Saturation limit of the millisecond counters.
    localparam logic [19:0] TIME_MAX = 20'hFFFFF;

    // One result item.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] out_key;
        logic        repeat_on;
        logic        last;
    } result_t;

endpackage

>>> src/key_repeat_generator.sv
// An accepted item is held in the input register and processed once the result
// buffer can take its results; they are registered into the result buffer.
// One item per cycle while the receiver is ready and items produce one result each;
// an item with two results holds up the next item until one has been taken (two-slot buffer).
// Reset (aresetn low, synchronous) restores configuration defaults, enables
// repeat, clears the held key and timers, and empties all buffers.
// Top level of the key repeat generator. Depends on krg_pkg.
`timescale 1ns / 1ps

module key_repeat_generator
    import krg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_key_code,
    input  logic        s_pressed,
    // Result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [15:0] m_out_key,
    output logic        m_repeat_on,
    output logic        m_last,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [15:0] delay_reg;
    logic [6:0]  interval_reg;
    logic [15:0] excluded_reg;
    logic [15:0] first_reg;
    logic [15:0] last_reg;

    // Repeat state.
    logic        enabled_reg,   enabled_next;
    logic        running_reg,   running_next;
    logic [15:0] held_reg,      held_next;
    logic [19:0] elapsed_reg,   elapsed_next;
    logic [19:0] threshold_reg, threshold_next;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_key_reg;
    logic        in_pressed_reg;

    // Two-slot result buffer; slot 0 is presented on the port.
    result_t     res0_reg, res1_reg;
    logic [1:0]  res_cnt_reg;

    // Results of the item in the input register.
    result_t     r0, r1;
    logic [1:0]  n_res;
    logic        proc_item;
    logic        handled;
    logic [19:0] elapsed_inc;
    logic [20:0] thr_sum;

    assign cfg_ready = 1'b1;

    // The held item is processed when the result buffer can take its results.
    assign proc_item = in_valid_reg &&
                       ((res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_ready));
    assign s_ready = !in_valid_reg || proc_item;

    assign m_valid     = (res_cnt_reg != 2'd0);
    assign m_action    = res0_reg.action;
    assign m_out_key   = res0_reg.out_key;
    assign m_repeat_on = res0_reg.repeat_on;
    assign m_last      = res0_reg.last;

    // Configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
            excluded_reg <= EXCLUDED_RST;
            first_reg    <= FIRST_RST;
            last_reg     <= LAST_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DELAY:    delay_reg    <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data[6:0];
                REG_EXCLUDED: excluded_reg <= cfg_data;
                REG_FIRST:    first_reg    <= cfg_data;
                REG_LAST:     last_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register: loads a new item whenever the previous one moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg     <= s_command;
            in_key_reg     <= s_key_code;
            in_pressed_reg <= s_pressed;
        end
    end

    // Item processing: next state and up to two results.
    always_comb begin
        enabled_next   = enabled_reg;
        running_next   = running_reg;
        held_next      = held_reg;
        elapsed_next   = elapsed_reg;
        threshold_next = threshold_reg;
        n_res          = 2'd0;
        r0             = '0;
        r1             = '0;

        handled = (in_key_reg >= first_reg) && (in_key_reg <= last_reg) &&
                  (in_key_reg != excluded_reg) && enabled_reg;
        elapsed_inc = (elapsed_reg == TIME_MAX) ? TIME_MAX : elapsed_reg + 20'd1;
        thr_sum = {1'b0, threshold_reg} + {14'd0, interval_reg};

        case (in_cmd_reg)
            CMD_KEY: begin
                if (!handled) begin
                    r0.action  = ACT_PASS;
                    r0.out_key = in_key_reg;
                    n_res      = 2'd1;
                end else if (in_pressed_reg) begin
                    if (running_reg) begin
                        r0.action  = ACT_RELEASE;
                        r0.out_key = held_reg;
                        r1.action  = ACT_PRESS;
                        r1.out_key = in_key_reg;
                        n_res      = 2'd2;
                    end else begin
                        r0.action  = ACT_PRESS;
                        r0.out_key = in_key_reg;
                        n_res      = 2'd1;
                    end
                    held_next      = in_key_reg;
                    running_next   = 1'b1;
                    elapsed_next   = '0;
                    threshold_next = {4'd0, delay_reg};
                end else if (in_key_reg == held_reg) begin
                    running_next = 1'b0;
                    r0.action    = ACT_RELEASE;
                    r0.out_key   = in_key_reg;
                    n_res        = 2'd1;
                end
            end
            CMD_TOGGLE: begin
                enabled_next = in_pressed_reg ? !enabled_reg : enabled_reg;
                r0.action    = ACT_LED;
                r0.out_key   = '0;
                n_res        = 2'd1;
                if (!enabled_next && running_reg) begin
                    running_next = 1'b0;
                    r1.action    = ACT_RELEASE;
                    r1.out_key   = held_reg;
                    n_res        = 2'd2;
                end
            end
            CMD_TICK: begin
                elapsed_next = elapsed_inc;
                if (running_reg && enabled_reg && (elapsed_inc > threshold_reg)) begin
                    r0.action      = ACT_RELEASE;
                    r0.out_key     = held_reg;
                    r1.action      = ACT_PRESS;
                    r1.out_key     = held_reg;
                    n_res          = 2'd2;
                    threshold_next = (thr_sum > {1'b0, TIME_MAX}) ? TIME_MAX
                                                                 : thr_sum[19:0];
                end
            end
            default: ;
        endcase

        // Every result reports the flag as it stands after this item.
        r0.repeat_on = enabled_next;
        r1.repeat_on = enabled_next;
        r0.last      = (n_res == 2'd1);
        r1.last      = (n_res == 2'd2);
    end

    // Repeat state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b1;
            running_reg   <= 1'b0;
            held_reg      <= '0;
            elapsed_reg   <= '0;
            threshold_reg <= '0;
        end else if (proc_item) begin
            enabled_reg   <= enabled_next;
            running_reg   <= running_next;
            held_reg      <= held_next;
            elapsed_reg   <= elapsed_next;
            threshold_reg <= threshold_next;
        end
    end

    // Result buffer: fills from the processed item, drains one item per handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (proc_item) begin
            res_cnt_reg <= n_res;
        end else if (m_valid && m_ready) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_item) begin
            res0_reg <= r0;
            res1_reg <= r1;
        end else if (m_valid && m_ready) begin
            res0_reg <= res1_reg;
        end
    end

`ifndef SYNTH
    // The buffer never holds more than two results.
    assert property (@(posedge aclk) disable iff (!aresetn) res_cnt_reg != 2'd3)
        else $error("result buffer overflow");

    // A full buffer always holds the first of a pair, which is never the last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_cnt_reg == 2'd2) |-> !res0_reg.last)
        else $error("first of two results marked last");

    // An empty input register always takes a new item.
    assert property (@(posedge aclk) disable iff (!aresetn) !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

    // A key can only be running while repeat is enabled.
    assert property (@(posedge aclk) disable iff (!aresetn) running_reg |-> enabled_reg)
        else $error("repeat running while disabled");
`endif

endmodule

>>> sim/krg_checker.sv
// Scoreboard for the key repeat generator: watches the input, result and
// configuration channels, predicts every result item and compares them.
// Depends on krg_pkg.
`timescale 1ns / 1ps

module krg_checker
    import krg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_key_code,
    input  logic        s_pressed,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_action,
    input  logic [15:0] m_out_key,
    input  logic        m_repeat_on,
    input  logic        m_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          autorepeat_total
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the configuration registers.
    logic [15:0] delay_ms;
    logic [6:0]  interval_ms;
    logic [15:0] excl_key;
    logic [15:0] range_lo;
    logic [15:0] range_hi;

    // Shadow copy of the repeat state.
    logic        rpt_enabled;
    logic        rpt_running;
    logic [15:0] held_key;
    logic [19:0] elapsed_ms;
    logic [19:0] threshold_ms;

    // Result items predicted but not yet seen on the result channel.
    result_t key_results [$];

    int mismatches   = 0;
    int results_seen = 0;
    int repeats_seen = 0;

    initial begin
        fail_count       = 0;
        pending          = 0;
        result_count     = 0;
        autorepeat_total = 0;
    end

    // The enable flag is reported as it stands when the item is built.
    function automatic result_t pack_result(input logic [1:0] act, input logic [15:0] key);
        result_t r;
        r.action    = act;
        r.out_key   = key;
        r.repeat_on = rpt_enabled;
        r.last      = 1'b0;
        return r;
    endfunction

    // Millisecond counters stop at the top of their 20-bit range.
    function automatic logic [19:0] sat_add(input logic [19:0] a, input logic [19:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[19:0];
    endfunction

    // Works out the result items of one accepted input item.
    task automatic predict_item(input logic [1:0] cmd, input logic [15:0] key,
                                input logic prs);
        result_t outs [2];
        int      n;
        logic    handled;
        n = 0;
        case (cmd)
            CMD_KEY: begin
                handled = (key >= range_lo) && (key <= range_hi) &&
                          (key != excl_key) && rpt_enabled;
                if (!handled) begin
                    outs[n] = pack_result(ACT_PASS, key);
                    n++;
                end else if (prs) begin
                    // A new press first lets go of the key being held.
                    if (rpt_running) begin
                        outs[n] = pack_result(ACT_RELEASE, held_key);
                        n++;
                    end
                    held_key     = key;
                    rpt_running  = 1'b1;
                    elapsed_ms   = '0;
                    threshold_ms = {4'd0, delay_ms};
                    outs[n] = pack_result(ACT_PRESS, key);
                    n++;
                end else if (key == held_key) begin
                    rpt_running = 1'b0;
                    outs[n] = pack_result(ACT_RELEASE, key);
                    n++;
                end
            end
            CMD_TOGGLE: begin
                if (prs) begin
                    rpt_enabled = !rpt_enabled;
                end
                outs[n] = pack_result(ACT_LED, 16'd0);
                n++;
                if (!rpt_enabled && rpt_running) begin
                    rpt_running = 1'b0;
                    outs[n] = pack_result(ACT_RELEASE, held_key);
                    n++;
                end
            end
            CMD_TICK: begin
                elapsed_ms = sat_add(elapsed_ms, 20'd1);
                if (rpt_running && rpt_enabled && (elapsed_ms > threshold_ms)) begin
                    outs[n] = pack_result(ACT_RELEASE, held_key);
                    n++;
                    outs[n] = pack_result(ACT_PRESS, held_key);
                    n++;
                    threshold_ms = sat_add(threshold_ms, {13'd0, interval_ms});
                    repeats_seen++;
                end
            end
            default: begin
            end
        endcase
        if (n > 0) begin
            outs[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            key_results.push_back(outs[i]);
        end
    endtask

    // Counts a failure and prints the first few of them.
    task automatic log_failure(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0.1f ns: %s: expected action/key/repeat_on/last %0d/%h/%b/%b",
                     $realtime, what, want.action, want.out_key, want.repeat_on, want.last);
            $display("    got action/key/repeat_on/last %0d/%h/%b/%b",
                     got.action, got.out_key, got.repeat_on, got.last);
        end
    endtask

    // Results are compared before new items are predicted: a result seen
    // at this edge always belongs to an older item.
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            delay_ms     = DELAY_RST;
            interval_ms  = INTERVAL_RST;
            excl_key     = EXCLUDED_RST;
            range_lo     = FIRST_RST;
            range_hi     = LAST_RST;
            rpt_enabled  = 1'b1;
            rpt_running  = 1'b0;
            held_key     = '0;
            elapsed_ms   = '0;
            threshold_ms = '0;
            key_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_action, m_out_key, m_repeat_on, m_last};
                results_seen++;
                if (key_results.size() == 0) begin
                    want = '0;
                    log_failure("result item with none expected", want, got);
                end else begin
                    want = key_results.pop_front();
                    if (got.action !== want.action || got.out_key !== want.out_key ||
                        got.repeat_on !== want.repeat_on || got.last !== want.last) begin
                        log_failure("result item mismatch", want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DELAY:    delay_ms    = cfg_data;
                    REG_INTERVAL: interval_ms = cfg_data[6:0];
                    REG_EXCLUDED: excl_key    = cfg_data;
                    REG_FIRST:    range_lo    = cfg_data;
                    REG_LAST:     range_hi    = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                predict_item(s_command, s_key_code, s_pressed);
            end
        end
        fail_count       <= mismatches;
        pending          <= key_results.size();
        result_count     <= results_seen;
        autorepeat_total <= repeats_seen;
    end

endmodule

>>> sim/tb.sv
// Top of the key repeat generator testbench: clock, reset, stimulus, idling
// and the verdict. Depends on krg_pkg, key_repeat_generator and krg_checker.
`timescale 1ns / 1ps

module tb
    import krg_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 8;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command  = CMD_KEY;
    logic [15:0] s_key_code = '0;
    logic        s_pressed  = 1'b0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [1:0]  m_action;
    logic [15:0] m_out_key;
    logic        m_repeat_on;
    logic        m_last;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = REG_DELAY;
    logic [15:0] cfg_data   = '0;

    int fail_count;
    int pending;
    int result_count;
    int autorepeat_total;

    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int items_sent       = 0;
    int cfg_writes       = 0;
    int settings_applied = 0;
    int idle_cycles      = 0;

    // Stimulus copy of the key range, used to aim key codes at its edges.
    logic [15:0] cur_excl  = EXCLUDED_RST;
    logic [15:0] cur_first = FIRST_RST;
    logic [15:0] cur_last  = LAST_RST;

    key_repeat_generator uut (.*);

    krg_checker chk (.*);

    always #6 aclk = ~aclk;

    // The receiver stalls at random, decided once per cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run when no channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one input item, after a random idle stretch, and waits until
    // it is accepted. Valid stays high if the next item follows at once.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] key, input logic prs);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_key_code <= key;
        s_pressed  <= prs;
        do @(posedge aclk); while (!s_ready);
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    // Stops the sender and waits until every predicted result has arrived,
    // then a little longer for items that produce no result.
    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
    endtask

    // Writes a full register set while the block is idle. Unused interval
    // bits carry noise, and one write goes to an index past the last register.
    task automatic apply_settings(input logic [15:0] dly, input logic [6:0] intv,
                                  input logic [15:0] excl, input logic [15:0] first,
                                  input logic [15:0] last);
        wait_quiet();
        write_reg(REG_DELAY, dly);
        write_reg(REG_INTERVAL, {9'($urandom), intv});
        write_reg(REG_EXCLUDED, excl);
        write_reg(REG_FIRST, first);
        write_reg(REG_LAST, last);
        write_reg(REG_LAST + 3'($urandom_range(3, 1)), 16'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_excl  = excl;
        cur_first = first;
        cur_last  = last;
        settings_applied++;
    endtask

    // Key codes mostly fall inside the handled range or on its edges.
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60 && cur_first <= cur_last) return 16'($urandom_range(cur_last, cur_first));
        if (r < 68) return cur_excl;
        if (r < 74) return cur_first;
        if (r < 80) return cur_last;
        if (r < 85) return cur_last + 16'd1;
        if (r < 90) return cur_first - 16'd1;
        return 16'($urandom);
    endfunction

    // Random traffic: mostly press, ticks and release of one key, mixed
    // with toggles, stray keys, stray ticks and unused commands. Halfway
    // through, the sender waits for the block to drain.
    task automatic run_phase(input int target);
        int          goal;
        int          r;
        int          nt;
        bit          drained;
        logic [15:0] k;
        goal    = items_sent + target;
        drained = 1'b0;
        while (items_sent < goal) begin
            if (!drained && items_sent >= goal - target / 2) begin
                wait_quiet();
                drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 65) begin
                k = pick_key();
                send_item(CMD_KEY, k, 1'b1);
                nt = $urandom_range(30, 0);
                repeat (nt) send_item(CMD_TICK, 16'($urandom), 1'($urandom));
                if ($urandom_range(4) == 0) begin
                    send_item(CMD_KEY, pick_key(), 1'b1);
                end else begin
                    send_item(CMD_KEY, k, 1'b0);
                end
            end else if (r < 72) begin
                send_item(CMD_TOGGLE, 16'($urandom), 1'($urandom));
                if ($urandom_range(3) != 0) begin
                    send_item(CMD_TOGGLE, 16'($urandom), 1'b1);
                end
            end else if (r < 85) begin
                send_item(CMD_KEY, pick_key(), 1'($urandom));
            end else if (r < 94) begin
                send_item(CMD_TICK, 16'($urandom), 1'($urandom));
            end else begin
                send_item(CMD_UNUSED, 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] dly;
        logic [6:0]  intv;
        logic [15:0] excl;
        logic [15:0] lo;
        logic [15:0] hi;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items on the reset configuration.
        send_item(CMD_KEY, 16'h0000, 1'b1);     // below the range: passes
        send_item(CMD_KEY, 16'hFFFF, 1'b0);     // above the range: passes
        send_item(CMD_KEY, EXCLUDED_RST, 1'b1); // excluded key passes
        send_item(CMD_KEY, FIRST_RST, 1'b1);    // first handled key
        send_item(CMD_KEY, LAST_RST, 1'b1);     // press while holding
        send_item(CMD_KEY, FIRST_RST, 1'b0);    // release of another key
        send_item(CMD_KEY, LAST_RST, 1'b0);     // release of the held key
        send_item(CMD_KEY, LAST_RST, 1'b0);     // release again, nothing running
        send_item(CMD_UNUSED, 16'hFFFF, 1'b1);  // ignored command
        send_item(CMD_TOGGLE, 16'h0000, 1'b0);  // indicator only
        send_item(CMD_KEY, 16'd30, 1'b1);
        send_item(CMD_TOGGLE, 16'hFFFF, 1'b1);  // disable, held key let go
        send_item(CMD_KEY, 16'd30, 1'b1);       // passes while disabled
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TOGGLE, 16'h0000, 1'b1);  // enable again

        // Short delay, zero interval, every code but the excluded 16'hFFFF handled.
        apply_settings(16'd2, 7'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(CMD_KEY, 16'h0000, 1'b1);
        repeat (4) send_item(CMD_TICK, 16'hFFFF, 1'b1);
        send_item(CMD_KEY, 16'hFFFF, 1'b1);
        send_item(CMD_KEY, 16'h0000, 1'b0);

        // Empty range: everything passes.
        apply_settings(16'd0, 7'd127, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(CMD_KEY, 16'd100, 1'b1);

        // One repeat, then a toggle that disables while running.
        apply_settings(16'd1, 7'd127, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_KEY, 16'd5, 1'b1);
        repeat (3) send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TOGGLE, 16'h0000, 1'b1);
        send_item(CMD_TOGGLE, 16'h0000, 1'b1);

        // Random phases, each with its own settings and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            case (p)
                0: begin dly = 16'd3; intv = 7'd1; excl = 16'd44; lo = 16'd4; hi = 16'd82; end
                1: begin dly = 16'd0; intv = 7'd0; excl = 16'd0; lo = 16'd0; hi = 16'hFFFF; end
                2: begin
                    dly = 16'hFFFF; intv = 7'd127; excl = 16'hFFFF;
                    lo = 16'h0000; hi = 16'hFFFF;
                end
                default: begin
                    dly  = 16'($urandom_range(12, 0));
                    intv = 7'($urandom_range(6, 0));
                    lo   = 16'($urandom_range(300, 0));
                    hi   = lo + 16'($urandom_range(400, 0));
                    excl = 16'($urandom_range(hi, lo));
                    if ($urandom_range(7) == 0) begin
                        {lo, hi} = {hi + 16'd1, lo};
                    end
                end
            endcase
            apply_settings(dly, intv, excl, lo, hi);
            run_phase(PHASE_ITEMS);
        end

        wait_quiet();
        $display("Run covered %0d input items and %0d result items under %0d register sets.",
                 items_sent, result_count, settings_applied);
        $display("It made %0d register writes and saw %0d auto-repeats.",
                 cfg_writes, autorepeat_total);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
